// ----- src/brr_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded random range reducer package
// Shared widths, command codes and the command item that travels from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package brr_pkg;

	localparam int ValueW  = 64;
	localparam int WordW   = 32;
	localparam int ShiftW  = 6;
	localparam int CountW  = 2;
	localparam int BitsW   = 7;
	localparam int GroupW  = 16;
	localparam int Groups  = ValueW / GroupW;
	localparam int GposW   = $clog2(GroupW);
	localparam int GselW   = $clog2(Groups);
	localparam int QDepth  = 2;
	localparam int QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCountW = $clog2(QDepth + 1);

	// Input item mode codes.
	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_WORD    = 1'b1;

	typedef logic [1:0] kind_t;

	// Command kinds handed to the back end.
	localparam kind_t CMD_WORD  = 2'd0;
	localparam kind_t CMD_SETUP = 2'd1;
	localparam kind_t CMD_ZERO  = 2'd2;

	typedef struct packed {
		kind_t              kind;
		logic               full;
		logic [ValueW-1:0]  data;          // range size for a setup, word for a word
		logic [ShiftW-1:0]  shift;
		logic [CountW-1:0]  first_cnt;
		logic [CountW-1:0]  total_cnt;
		logic [WordW-1:0]   low_mask;
		logic [WordW-1:0]   high_mask;
		logic               first_lim_hi;  // reject limit is 2^32, else 0
		logic               second_lim_hi;
	} cmd_t;

	// A mask with the given number of low bits set, saturating at a full word.
	function automatic logic [WordW-1:0] mask_of(input logic [ShiftW-1:0] nbits);
		logic [WordW-1:0] m;
		if (nbits >= ShiftW'(WordW)) begin
			m = '1;
		end else begin
			m = ~({WordW{1'b1}} << nbits);
		end
		return m;
	endfunction

endpackage

// ----- src/brr_if.sv -----
// ----------------------------------------------------------------------------
// Bounded random range reducer channels
// Valid/ready channel for input items and for result items.
// ----------------------------------------------------------------------------
interface brr_in_if import brr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [ValueW-1:0] bound;
	logic [WordW-1:0]  random_word;

	modport source (output valid, output mode, output bound, output random_word,
		input ready);
	modport sink (input valid, input mode, input bound, input random_word,
		output ready);
endinterface

interface brr_out_if import brr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ValueW-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ----- src/brr_front.sv -----
// ----------------------------------------------------------------------------
// Bounded random range reducer front end
// Accepts input items, classifies them and works out the draw set-up for a
// request: bit count from the top set bit of the bound, word counts, shift,
// masks and reject limits.
// ----------------------------------------------------------------------------
module brr_front import brr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	brr_in_if.sink   items,
	output cmd_t     cmd,
	output logic     cmd_valid,
	input  logic     cmd_ready
);

	logic                          valid_s1;
	kind_t                         kind_s1;
	logic [ValueW-1:0]             data_s1;
	logic                          full_s1;
	logic [Groups-1:0]             grp_nz_s1;
	logic [Groups-1:0][GposW-1:0]  grp_pos_s1;

	kind_t                         kind_d;
	logic [ValueW-1:0]             data_d;
	logic [Groups-1:0]             grp_nz_d;
	logic [Groups-1:0][GposW-1:0]  grp_pos_d;
	logic                          accept;

	logic [ShiftW-1:0]             msb;
	logic [BitsW-1:0]              bits;
	logic                          two_words;
	logic [ShiftW-1:0]             shift;

	// Position of the highest set bit in one group of the bound.
	function automatic logic [GposW-1:0] lead_pos(input logic [GroupW-1:0] x);
		logic [GposW-1:0] p;
		p = '0;
		for (int i = 0; i < GroupW; i++) begin
			if (x[i]) begin
				p = GposW'(i);
			end
		end
		return p;
	endfunction

	assign items.ready = !valid_s1 || cmd_ready;
	assign accept      = items.valid && items.ready;

	always_comb begin
		for (int g = 0; g < Groups; g++) begin
			grp_nz_d[g]  = |items.bound[g*GroupW +: GroupW];
			grp_pos_d[g] = lead_pos(items.bound[g*GroupW +: GroupW]);
		end
		if (items.mode == MODE_WORD) begin
			kind_d = CMD_WORD;
			data_d = {{(ValueW-WordW){1'b0}}, items.random_word};
		end else begin
			kind_d = (items.bound == '0) ? CMD_ZERO : CMD_SETUP;
			data_d = items.bound + ValueW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind_d;
			data_s1    <= data_d;
			full_s1    <= &items.bound;
			grp_nz_s1  <= grp_nz_d;
			grp_pos_s1 <= grp_pos_d;
		end
	end

	// The bit count is the bit length of the bound itself.
	always_comb begin
		msb = '0;
		for (int g = 0; g < Groups; g++) begin
			if (grp_nz_s1[g]) begin
				msb = {GselW'(g), grp_pos_s1[g]};
			end
		end
		bits      = {1'b0, msb} + BitsW'(1);
		two_words = bits > BitsW'(WordW);
		shift     = two_words ? bits[ShiftW:1] : bits[ShiftW-1:0];

		cmd.kind          = kind_s1;
		cmd.full          = full_s1;
		cmd.data          = data_s1;
		cmd.shift         = shift;
		cmd.total_cnt     = two_words ? CountW'(2) : CountW'(1);
		cmd.first_cnt     = (two_words && !bits[0]) ? CountW'(2) : CountW'(1);
		cmd.low_mask      = mask_of(shift);
		cmd.high_mask     = (shift >= ShiftW'(WordW - 1)) ? '1 : mask_of(shift + ShiftW'(1));
		cmd.first_lim_hi  = shift <= ShiftW'(WordW);
		cmd.second_lim_hi = !full_s1 && (shift < ShiftW'(WordW));
	end

	assign cmd_valid = valid_s1;

endmodule

// ----- src/brr_queue.sv -----
// ----------------------------------------------------------------------------
// Bounded random range reducer command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module brr_queue import brr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t push_cmd,
	input  logic push_valid,
	output logic push_ready,
	output cmd_t pop_cmd,
	output logic pop_valid,
	input  logic pop_ready
);

	cmd_t                entry_q [QDepth];
	logic [QPtrW-1:0]    wr_ptr_q;
	logic [QPtrW-1:0]    rd_ptr_q;
	logic [QCountW-1:0]  count_q;
	logic                push;
	logic                pop;

	function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
		return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
	endfunction

	assign push_ready = count_q != QCountW'(QDepth);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCountW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCountW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- src/brr_back.sv -----
// ----------------------------------------------------------------------------
// Bounded random range reducer back end
// Holds the draw state, folds accepted words into the accumulator, rejects
// oversized values and drives the result register.
// ----------------------------------------------------------------------------
module brr_back import brr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	brr_out_if.source results
);

	logic               busy_q;
	logic [ValueW-1:0]  range_q;
	logic               full_q;
	logic [ShiftW-1:0]  shift_q;
	logic [CountW-1:0]  first_cnt_q;
	logic [CountW-1:0]  total_cnt_q;
	logic [WordW-1:0]   low_mask_q;
	logic [WordW-1:0]   high_mask_q;
	logic               first_lim_hi_q;
	logic               second_lim_hi_q;
	logic [ValueW-1:0]  acc_q;
	logic [CountW-1:0]  taken_q;
	logic               out_valid_q;
	logic [ValueW-1:0]  value_q;

	logic               take;
	logic               first_phase;
	logic               lim_hi;
	logic [ShiftW-1:0]  sh;
	logic [WordW-1:0]   mask;
	logic [ValueW-1:0]  acc_next;
	logic [CountW-1:0]  taken_next;
	logic               word_used;
	logic               done;
	logic               oversize;
	logic               emit;

	assign cmd_ready = !out_valid_q || results.ready;
	assign take      = cmd_valid && cmd_ready;

	always_comb begin
		first_phase = taken_q < first_cnt_q;
		lim_hi      = first_phase ? first_lim_hi_q : second_lim_hi_q;
		sh          = first_phase ? shift_q : shift_q + ShiftW'(1);
		mask        = first_phase ? low_mask_q : high_mask_q;
		// The shifted accumulator has zeros wherever the masked word has bits.
		acc_next    = (acc_q << sh) | {{(ValueW-WordW){1'b0}}, cmd.data[WordW-1:0] & mask};
		taken_next  = taken_q + CountW'(1);
		done        = !(taken_next < total_cnt_q);
		oversize    = !full_q && (acc_next >= range_q);
		word_used   = take && (cmd.kind == CMD_WORD) && busy_q && lim_hi;
		emit        = (take && (cmd.kind == CMD_ZERO)) || (word_used && done && !oversize);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q          <= 1'b0;
			range_q         <= '0;
			full_q          <= 1'b0;
			shift_q         <= '0;
			first_cnt_q     <= '0;
			total_cnt_q     <= '0;
			low_mask_q      <= '0;
			high_mask_q     <= '0;
			first_lim_hi_q  <= 1'b0;
			second_lim_hi_q <= 1'b0;
			acc_q           <= '0;
			taken_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			// A new result loads the register; otherwise a taken one leaves it.
			out_valid_q <= emit || (out_valid_q && !results.ready);
			if (take) begin
				case (cmd.kind)
					CMD_ZERO: begin
						busy_q  <= 1'b0;
						acc_q   <= '0;
						taken_q <= '0;
					end
					CMD_SETUP: begin
						busy_q          <= 1'b1;
						range_q         <= cmd.data;
						full_q          <= cmd.full;
						shift_q         <= cmd.shift;
						first_cnt_q     <= cmd.first_cnt;
						total_cnt_q     <= cmd.total_cnt;
						low_mask_q      <= cmd.low_mask;
						high_mask_q     <= cmd.high_mask;
						first_lim_hi_q  <= cmd.first_lim_hi;
						second_lim_hi_q <= cmd.second_lim_hi;
						acc_q           <= '0;
						taken_q         <= '0;
					end
					CMD_WORD: begin
						if (word_used) begin
							if (!done) begin
								acc_q   <= acc_next;
								taken_q <= taken_next;
							end else begin
								acc_q   <= '0;
								taken_q <= '0;
								if (!oversize) begin
									busy_q <= 1'b0;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q <= (cmd.kind == CMD_ZERO) ? '0 : acc_next;
		end
	end

	assign results.valid = out_valid_q;
	assign results.value = value_q;

endmodule

// ----- src/bounded_random_range_reducer.sv -----
// ----------------------------------------------------------------------------
// Bounded random range reducer
// Turns raw 32-bit random words into a uniform integer from 0 to a requested
// bound with the independent-bits construction.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                        Handshake
//   items     in         mode, bound[63:0], word[31:0]  valid/ready
//   results   out        value[63:0]                    valid/ready
//
// Every item, request or word, passes the front register, the queue and the back
// end, so the block takes one item per clock while no result is stalled.
// A result then waits in the result register of the back end until it is taken.
// The back end stalls only while the result register holds an untaken result;
// the two-entry queue lets the front keep taking items meanwhile.
// Reset clears the draw state, the queue and the result register at once.
//
// A request sets the draw up: the bit count is the bit length of the bound,
// the words per assembly are one or two, and the first phase holds
// n - (w mod n) words of w/n bits each, the rest one bit more. A request with
// bound zero gives zero at once and ends any draw. A request while a draw is
// running restarts it; a word that arrives with no draw running is dropped.
// A finished value at or above bound + 1 restarts the assembly. The full
// 64-bit range takes two whole words, high word first, and is never rejected.
// ----------------------------------------------------------------------------
module bounded_random_range_reducer import brr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	brr_in_if.sink    items,
	brr_out_if.source results
);

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	// Classification and set-up arithmetic.
	brr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// Decouples the front from stalls on the result side.
	brr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (back_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// Draw state, accumulation, rejection and the result register.
	brr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.results   (results)
	);

endmodule

// ----- src/brr_checker.sv -----
// ----------------------------------------------------------------------------
// Bounded random range reducer port checker
// Watches the top-level ports and checks results against requests seen.
// ----------------------------------------------------------------------------
module brr_checker import brr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_mode,
	input logic [ValueW-1:0] in_bound,
	input logic              out_valid,
	input logic              out_ready,
	input logic [ValueW-1:0] out_value
);

	logic              seen_q;
	logic [ValueW-1:0] max_bound_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			max_bound_q <= '0;
		end else if (in_valid && in_ready && (in_mode == MODE_REQUEST)) begin
			seen_q <= 1'b1;
			if (in_bound > max_bound_q) begin
				max_bound_q <= in_bound;
			end
		end
	end

	// A pending result stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value))
		else $error("stalled result changed");

	// Nothing is offered right after reset.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered right after reset");

	// Every result follows some request and lies within the largest bound seen.
	a_value_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q && (out_value <= max_bound_q))
		else $error("result outside every requested range");

endmodule

bind bounded_random_range_reducer brr_checker u_brr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_mode   (items.mode),
	.in_bound  (items.bound),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.value)
);
